// File: rtl/ubxfr_pkg.sv
// Shared package for the UBX frame receiver.
// Holds frame constants, result codes and the controller/datapath interface structs.
// No dependencies.
package ubxfr_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_A         = 8'hB5;
    localparam logic [7:0] SYNC_B         = 8'h62;
    localparam logic [7:0] ACK_CLASS      = 8'h05;
    localparam logic [7:0] ACK_ID_ACK     = 8'h01;
    localparam logic [7:0] ACK_ID_NAK     = 8'h00;
    localparam int         FRAME_OVERHEAD = 8;
    localparam int         MAX_RES        = 64;
    localparam int         RES_W          = $clog2(MAX_RES + 1);

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PAYLOAD = 504;
    localparam int DEF_RING_DEPTH  = 1024;

    // Window offsets the controller loads
    localparam logic [2:0] OFF_SYNC_A = 3'd0;
    localparam logic [2:0] OFF_SYNC_B = 3'd1;
    localparam logic [2:0] OFF_CLASS  = 3'd2;
    localparam logic [2:0] OFF_LEN_LO = 3'd4;
    localparam logic [2:0] OFF_LEN_HI = 3'd5;

    // Acknowledge status codes
    localparam logic [1:0] ACK_ST_NONE = 2'd0;
    localparam logic [1:0] ACK_ST_ACK  = 2'd1;
    localparam logic [1:0] ACK_ST_NAK  = 2'd2;
    localparam logic [1:0] ACK_ST_BAD  = 2'd3;

    // Input op and result kind codes
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_READ   = 1'b1;
    localparam logic KIND_DESC = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Register indexes on the config port
    localparam logic [1:0] REG_ACK_WAIT  = 2'd0;
    localparam logic [1:0] REG_ACK_CLASS = 2'd1;
    localparam logic [1:0] REG_ACK_ID    = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       push;       // write rx byte, grow window
        logic       rd_load;    // capture read position
        logic       rd_sub;     // reduce read position by ring depth
        logic       mem_rd_pos; // read ring at read position
        logic       mem_rd_win; // read ring at window offset
        logic       off_set;
        logic [2:0] off_val;
        logic       off_inc;
        logic       drop1;
        logic       len_lo;
        logic       len_hi;
        logic       ck_clr;
        logic       ck_acc;
        logic       ck_a_cap;
        logic       n_clr;
        logic       emit;       // park descriptor, drop frame
        logic       out_read;   // load read result into output
        logic       out_fin;    // move parked descriptor out as last
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic pend_valid;
        logic cnt_ge2;
        logic cnt_is1;
        logic cnt_lt6;
        logic n_lt_max;
        logic q_sync_a;
        logic q_sync_b;
        logic len_big;
        logic tot_gt_cnt;
        logic ck_body;
        logic ck_at_a;
        logic ck_ok;
        logic rd_big;
    } sts_t;

endpackage

// File: rtl/ubxfr_ctrl.sv
// Scan controller for the UBX frame receiver.
// Sequences push, resync, header, checksum and descriptor steps. Uses ubxfr_pkg.
module ubxfr_ctrl
    import ubxfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_op,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_RD_MOD  = 17'b00000000000000010,
        S_RD_WAIT = 17'b00000000000000100,
        S_SC_TOP  = 17'b00000000000001000,
        S_SY_RD   = 17'b00000000000010000,
        S_SY_EV   = 17'b00000000000100000,
        S_B1_RD   = 17'b00000000001000000,
        S_B1_EV   = 17'b00000000010000000,
        S_L4_RD   = 17'b00000000100000000,
        S_L4_EV   = 17'b00000001000000000,
        S_L5_RD   = 17'b00000010000000000,
        S_L5_EV   = 17'b00000100000000000,
        S_LN_CK   = 17'b00001000000000000,
        S_CK_RD   = 17'b00010000000000000,
        S_CK_EV   = 17'b00100000000000000,
        S_EMIT    = 17'b01000000000000000,
        S_FIN     = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_READ)
                    begin
                        cmd.rd_load = 1'b1;
                        state_next  = S_RD_MOD;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        cmd.n_clr  = 1'b1;
                        state_next = S_SC_TOP;
                    end
                end
            end
            S_RD_MOD:
            begin
                if (sts.rd_big)
                begin
                    cmd.rd_sub = 1'b1;
                end
                else
                begin
                    cmd.mem_rd_pos = 1'b1;
                    state_next     = S_RD_WAIT;
                end
            end
            S_RD_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SC_TOP:
            begin
                if (sts.cnt_ge2 && sts.n_lt_max)
                begin
                    cmd.off_set = 1'b1;
                    cmd.off_val = OFF_SYNC_A;
                    state_next  = S_SY_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SY_RD:
            begin
                cmd.mem_rd_win = 1'b1;
                state_next     = S_SY_EV;
            end
            // Hunt for the first sync byte, one byte per pass
            S_SY_EV:
            begin
                if (!sts.q_sync_a)
                begin
                    cmd.drop1  = 1'b1;
                    state_next = sts.cnt_is1 ? S_FIN : S_SY_RD;
                end
                else if (sts.cnt_lt6)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.off_set = 1'b1;
                    cmd.off_val = OFF_SYNC_B;
                    state_next  = S_B1_RD;
                end
            end
            S_B1_RD:
            begin
                cmd.mem_rd_win = 1'b1;
                state_next     = S_B1_EV;
            end
            S_B1_EV:
            begin
                if (!sts.q_sync_b)
                begin
                    cmd.drop1  = 1'b1;
                    state_next = S_SC_TOP;
                end
                else
                begin
                    cmd.off_set = 1'b1;
                    cmd.off_val = OFF_LEN_LO;
                    state_next  = S_L4_RD;
                end
            end
            S_L4_RD:
            begin
                cmd.mem_rd_win = 1'b1;
                state_next     = S_L4_EV;
            end
            S_L4_EV:
            begin
                cmd.len_lo  = 1'b1;
                cmd.off_set = 1'b1;
                cmd.off_val = OFF_LEN_HI;
                state_next  = S_L5_RD;
            end
            S_L5_RD:
            begin
                cmd.mem_rd_win = 1'b1;
                state_next     = S_L5_EV;
            end
            S_L5_EV:
            begin
                cmd.len_hi = 1'b1;
                state_next = S_LN_CK;
            end
            S_LN_CK:
            begin
                if (sts.len_big)
                begin
                    cmd.drop1  = 1'b1;
                    state_next = S_SC_TOP;
                end
                else if (sts.tot_gt_cnt)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.off_set = 1'b1;
                    cmd.off_val = OFF_CLASS;
                    cmd.ck_clr  = 1'b1;
                    state_next  = S_CK_RD;
                end
            end
            S_CK_RD:
            begin
                cmd.mem_rd_win = 1'b1;
                state_next     = S_CK_EV;
            end
            // Fletcher sums over the body, then compare both check bytes
            S_CK_EV:
            begin
                if (sts.ck_body)
                begin
                    cmd.ck_acc  = 1'b1;
                    cmd.off_inc = 1'b1;
                    state_next  = S_CK_RD;
                end
                else if (sts.ck_at_a)
                begin
                    cmd.ck_a_cap = 1'b1;
                    cmd.off_inc  = 1'b1;
                    state_next   = S_CK_RD;
                end
                else if (sts.ck_ok)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.drop1  = 1'b1;
                    state_next = S_SC_TOP;
                end
            end
            // Park the descriptor; a previously parked one goes out first
            S_EMIT:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_SC_TOP;
                end
            end
            S_FIN:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.out_fin = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ubxfr_dp.sv
// Datapath for the UBX frame receiver: byte ring, window pointers,
// checksum unit, descriptor slot and output register. Uses ubxfr_pkg.
module ubxfr_dp
    import ubxfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
    parameter int RING_DEPTH  = DEF_RING_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [7:0]  rx_byte,
    input  logic [9:0]  read_pos,
    input  logic        ack_wait,
    input  logic [7:0]  ack_class,
    input  logic [7:0]  ack_id,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        out_kind,
    output logic        out_last,
    output logic [44:0] out_data
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int TOT_W  = 17;

    // Window offset plus base, wrapped once around the ring
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(RING_DEPTH))
        begin
            s = s - SUM_W'(RING_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    logic [7:0]        ring_mem [RING_DEPTH];
    logic [7:0]        mem_q_reg;
    logic [ADDR_W-1:0] start_reg, wpos_reg;
    logic [CNT_W-1:0]  count_reg, off_reg;
    logic [9:0]        rd_reg;
    logic [15:0]       len_reg;
    logic [7:0]        a_reg, b_reg, cls_reg, id_reg, p0_reg, p1_reg;
    logic              a_ok_reg;
    logic [RES_W-1:0]  n_reg;

    // Parked descriptor
    logic              pend_valid_reg;
    logic [7:0]        pend_cls_reg, pend_id_reg;
    logic [8:0]        pend_len_reg;
    logic [9:0]        pend_start_reg;
    logic [1:0]        pend_ack_reg;

    // Output register
    logic              out_valid_reg, out_kind_reg, out_last_reg;
    logic [44:0]       out_data_reg;

    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  off_p2;
    logic [7:0]        a_sum;
    logic [1:0]        ack_st;
    logic              out_free;
    logic [ADDR_W-1:0] rd_addr;

    assign total    = TOT_W'(len_reg) + TOT_W'(FRAME_OVERHEAD);
    assign off_p2   = TOT_W'(off_reg) + TOT_W'(2);
    assign a_sum    = a_reg + mem_q_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign rd_addr  = cmd.mem_rd_pos ? ADDR_W'(rd_reg) : ring_add(start_reg, off_reg);

    // Acknowledge classification of the frame just checked
    always_comb
    begin
        ack_st = ACK_ST_NONE;
        if (cls_reg == ACK_CLASS && (id_reg == ACK_ID_ACK || id_reg == ACK_ID_NAK))
        begin
            if (len_reg != 16'd2)
            begin
                ack_st = ACK_ST_BAD;
            end
            else if (ack_wait && p0_reg == ack_class && p1_reg == ack_id)
            begin
                ack_st = (id_reg == ACK_ID_ACK) ? ACK_ST_ACK : ACK_ST_NAK;
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.out_free   = out_free;
        sts.pend_valid = pend_valid_reg;
        sts.cnt_ge2    = count_reg >= CNT_W'(2);
        sts.cnt_is1    = count_reg == CNT_W'(1);
        sts.cnt_lt6    = count_reg < CNT_W'(6);
        sts.n_lt_max   = n_reg < RES_W'(MAX_RES);
        sts.q_sync_a   = mem_q_reg == SYNC_A;
        sts.q_sync_b   = mem_q_reg == SYNC_B;
        sts.len_big    = 32'(len_reg) > 32'(MAX_PAYLOAD);
        sts.tot_gt_cnt = total > TOT_W'(count_reg);
        sts.ck_body    = off_p2 < total;
        sts.ck_at_a    = off_p2 == total;
        sts.ck_ok      = a_ok_reg && (b_reg == mem_q_reg);
        sts.rd_big     = 32'(rd_reg) >= 32'(RING_DEPTH);
    end

    // Byte ring, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[wpos_reg] <= rx_byte;
        end
        if (cmd.mem_rd_pos || cmd.mem_rd_win)
        begin
            mem_q_reg <= ring_mem[rd_addr];
        end
    end

    // Window pointers and result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            count_reg <= '0;
            wpos_reg  <= '0;
            n_reg     <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                wpos_reg <= ring_add(wpos_reg, CNT_W'(1));
                if (count_reg == CNT_W'(RING_DEPTH))
                begin
                    start_reg <= ring_add(start_reg, CNT_W'(1));
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (cmd.drop1)
            begin
                start_reg <= ring_add(start_reg, CNT_W'(1));
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.emit)
            begin
                start_reg <= ring_add(start_reg, total[CNT_W-1:0]);
                count_reg <= count_reg - total[CNT_W-1:0];
            end
            if (cmd.n_clr)
            begin
                n_reg <= '0;
            end
            else if (cmd.emit)
            begin
                n_reg <= n_reg + RES_W'(1);
            end
        end
    end

    // Scan registers: read position, offset, length, checksum, captured frame bytes, descriptor fields
    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            rd_reg <= read_pos;
        end
        else if (cmd.rd_sub)
        begin
            rd_reg <= rd_reg - 10'(RING_DEPTH);
        end
        if (cmd.off_set)
        begin
            off_reg <= CNT_W'(cmd.off_val);
        end
        else if (cmd.off_inc)
        begin
            off_reg <= off_reg + CNT_W'(1);
        end
        if (cmd.len_lo)
        begin
            len_reg[7:0] <= mem_q_reg;
        end
        if (cmd.len_hi)
        begin
            len_reg[15:8] <= mem_q_reg;
        end
        if (cmd.ck_clr)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (cmd.ck_acc)
        begin
            a_reg <= a_sum;
            b_reg <= b_reg + a_sum;
            case (off_reg)
                CNT_W'(2): cls_reg <= mem_q_reg;
                CNT_W'(3): id_reg  <= mem_q_reg;
                CNT_W'(6): p0_reg  <= mem_q_reg;
                CNT_W'(7): p1_reg  <= mem_q_reg;
                default:   ;
            endcase
        end
        if (cmd.ck_a_cap)
        begin
            a_ok_reg <= (a_reg == mem_q_reg);
        end
        if (cmd.emit)
        begin
            pend_cls_reg   <= cls_reg;
            pend_id_reg    <= id_reg;
            pend_len_reg   <= len_reg[8:0];
            pend_start_reg <= 10'(ring_add(start_reg, CNT_W'(6)));
            pend_ack_reg   <= ack_st;
        end
    end

    // Descriptor slot and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.out_fin)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_read || cmd.out_fin || (cmd.emit && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_read)
        begin
            out_kind_reg <= KIND_READ;
            out_last_reg <= 1'b1;
            out_data_reg <= {mem_q_reg, 37'd0};
        end
        else if (cmd.out_fin || (cmd.emit && pend_valid_reg))
        begin
            out_kind_reg <= KIND_DESC;
            out_last_reg <= cmd.out_fin;
            out_data_reg <= {8'd0, pend_ack_reg, pend_start_reg, pend_len_reg,
                             pend_id_reg, pend_cls_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/ubx_frame_receiver_unit.sv
// UBX frame receiver: pushed bytes go into a RING_DEPTH byte ring and are scanned for
// sync, header, length and 8-bit Fletcher checksum; each good frame yields a descriptor
// (class, id, payload length, ring position, acknowledge status), the last one of a push
// flagged by tlast. A push with no complete frame gives no result. A read op returns one
// ring byte; RING_DEPTH is subtracted from the position while it is RING_DEPTH or more.
// The ring has one read port: every byte read (sync hunt, header, checksum walk over
// len+6 bytes) takes a read state and an evaluate state. No new input is taken until the
// current op finishes. Ring entries are undefined until written; there is no clearing pass.
// Depends on ubxfr_pkg, ubxfr_ctrl and ubxfr_dp.
module ubx_frame_receiver_unit
    import ubxfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
    parameter int RING_DEPTH  = DEF_RING_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // rx_byte[7:0], read_pos[17:8], zero[23:18]
    input  logic        s_tuser,  // op
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // msg_class[7:0], msg_id[15:8], payload_len[24:16],
                                  // payload_start[34:25], ack_status[36:35],
                                  // read_data[44:37], zero[47:45]
    output logic        m_tuser,  // kind
    output logic        m_tlast,
    // Config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t        cmd;
    sts_t        sts;
    logic        ack_wait_reg;
    logic [7:0]  ack_class_reg, ack_id_reg;
    logic [44:0] out_data;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_wait_reg  <= 1'b0;
            ack_class_reg <= '0;
            ack_id_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ACK_WAIT:  ack_wait_reg  <= pwdata[0];
                REG_ACK_CLASS: ack_class_reg <= pwdata[7:0];
                REG_ACK_ID:    ack_id_reg    <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_ACK_WAIT:  prdata = {31'd0, ack_wait_reg};
            REG_ACK_CLASS: prdata = {24'd0, ack_class_reg};
            REG_ACK_ID:    prdata = {24'd0, ack_id_reg};
            default:       prdata = '0;
        endcase
    end

    ubxfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ubxfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (s_tdata[7:0]),
        .read_pos  (s_tdata[17:8]),
        .ack_wait  (ack_wait_reg),
        .ack_class (ack_class_reg),
        .ack_id    (ack_id_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_last  (m_tlast),
        .out_data  (out_data)
    );

    assign m_tdata = {3'd0, out_data};

    // A read result always closes its transfer group
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_READ) |-> m_tlast)
        else $error("read result without tlast");

    // No descriptor may stay parked while new input is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.pend_valid)
        else $error("parked descriptor while idle");

    // A read op keeps the input closed on the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_READ) |=> !s_tready)
        else $error("input reopened during read");

endmodule
